/* src/charset_candidate_enumerator_macros.svh */
// Assertion macros shared by the charset candidate enumerator RTL.
// Included by the top level; depends on nothing else.
`ifndef CHARSET_CANDIDATE_ENUMERATOR_MACROS_SVH
`define CHARSET_CANDIDATE_ENUMERATOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CCENUM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CCENUM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ccenum_pkg.sv */
// Shared types and constants for the charset candidate enumerator.
// Used by ccenum_front, ccenum_back and charset_candidate_enumerator; no dependencies.
package ccenum_pkg;

  localparam int MAX_LEN     = 32;
  localparam int LEN_W       = $clog2(MAX_LEN + 1);
  localparam int POS_W       = $clog2(MAX_LEN);
  localparam int SYM_W       = 8;
  localparam int NSYM        = 1 << SYM_W;
  localparam int CFG_W       = 8;
  localparam int REG_IDX_W   = 2;
  // Queue depths must be powers of two so that the pointers wrap on their own.
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_SUCC_WR   = 2'd0,
    MODE_PREFIX_WR = 2'd1,
    MODE_START     = 2'd2,
    MODE_NEXT      = 2'd3
  } mode_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PREFIX_LEN = 2'd0,
    REG_MAX_LEN    = 2'd1,
    REG_FIRST_SYM  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_WALK = 2'd1,
    PHASE_DONE = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_EMIT    = 3'd1,
    ST_ADVANCE = 3'd2,
    ST_LOOKUP  = 3'd3,
    ST_CHECK   = 3'd4
  } eng_state_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [SYM_W-1:0] slot;
    logic [SYM_W-1:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol_out;
    logic [POS_W-1:0] position;
    logic [LEN_W-1:0] candidate_length;
    logic             last_byte;
    logic             exhausted;
  } result_t;

  typedef struct packed {
    mode_t            kind;
    logic [SYM_W-1:0] slot;
    logic [SYM_W-1:0] value;
    logic             slot_in_range;
  } cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0] prefix_length;
    logic [LEN_W-1:0] maximum_length;
    logic [SYM_W-1:0] first_symbol;
  } cfg_t;

endpackage

/* src/ccenum_front.sv */
// Front end of the enumerator: accepts input transactions, decodes them into
// commands and holds them in a short queue. Depends on ccenum_pkg.
module ccenum_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  ccenum_pkg::in_item_t item,
  output logic                 cmd_valid,
  output ccenum_pkg::cmd_t     cmd,
  input  logic                 cmd_ready
);

  ccenum_pkg::cmd_t                   q [ccenum_pkg::Q_DEPTH];
  logic [ccenum_pkg::Q_PTR_W-1:0]     wr_ptr;
  logic [ccenum_pkg::Q_PTR_W-1:0]     rd_ptr;
  logic [ccenum_pkg::Q_CNT_W-1:0]     count;
  ccenum_pkg::cmd_t                   decoded;
  logic                               accept;
  logic                               take;

  // Prefix writes beyond the candidate buffer are dropped, so flag them here.
  always_comb begin
    decoded.kind          = ccenum_pkg::mode_t'(item.mode);
    decoded.slot          = item.slot;
    decoded.value         = item.byte_value;
    decoded.slot_in_range = item.slot < ccenum_pkg::SYM_W'(ccenum_pkg::MAX_LEN);
  end

  assign full      = count == ccenum_pkg::Q_CNT_W'(ccenum_pkg::Q_DEPTH);
  assign cmd_valid = count != '0;
  assign cmd       = q[rd_ptr];
  assign accept    = push && !full;
  assign take      = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + ccenum_pkg::Q_CNT_W'(accept) - ccenum_pkg::Q_CNT_W'(take);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= decoded;
    end
  end

endmodule

/* src/ccenum_back.sv */
// Back end of the enumerator: successor memory, candidate buffer, the walk
// sequencer and the result queue. Depends on ccenum_pkg.
module ccenum_back (
  input  logic                clk,
  input  logic                rst,
  input  ccenum_pkg::cfg_t    cfg,
  input  logic                cmd_valid,
  input  ccenum_pkg::cmd_t    cmd,
  output logic                cmd_ready,
  output logic                empty,
  input  logic                pop,
  output ccenum_pkg::result_t result
);

  localparam int SW = ccenum_pkg::SYM_W;
  localparam int LW = ccenum_pkg::LEN_W;
  localparam int PW = ccenum_pkg::POS_W;

  ccenum_pkg::eng_state_t state, state_next;
  ccenum_pkg::phase_t     phase, phase_next;
  logic [LW-1:0]          cur_len, cur_len_next;
  logic [PW-1:0]          idx, idx_next;

  // Candidate buffer: one write port, one read port.
  logic [SW-1:0] cand [ccenum_pkg::MAX_LEN];
  logic          cand_we;
  logic [PW-1:0] cand_waddr;
  logic [SW-1:0] cand_wdata;
  logic [PW-1:0] cand_raddr;
  logic [SW-1:0] cand_rdata;

  // Successor memory with registered read; valid bits stand in for the zero reset.
  logic [SW-1:0] succ_mem [ccenum_pkg::NSYM];
  logic          succ_valid [ccenum_pkg::NSYM];
  logic          succ_we;
  logic          succ_re;
  logic [SW-1:0] succ_raddr;
  logic [SW-1:0] succ_rdata;
  logic          succ_rvalid;
  logic [SW-1:0] succ_next_sym;

  // Result queue.
  ccenum_pkg::result_t             oq [ccenum_pkg::Q_DEPTH];
  logic [ccenum_pkg::Q_PTR_W-1:0]  owr_ptr;
  logic [ccenum_pkg::Q_PTR_W-1:0]  ord_ptr;
  logic [ccenum_pkg::Q_CNT_W-1:0]  ocount;
  logic                            out_full;
  logic                            out_push;
  logic                            out_pop;
  ccenum_pkg::result_t             out_data;

  logic [LW-1:0] limit;
  logic [LW-1:0] len_dec;

  assign cand_rdata    = cand[cand_raddr];
  assign succ_next_sym = succ_rvalid ? succ_rdata : '0;
  assign limit         = (cfg.maximum_length > LW'(ccenum_pkg::MAX_LEN)) ?
                         LW'(ccenum_pkg::MAX_LEN) : cfg.maximum_length;
  assign len_dec       = cur_len - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ccenum_pkg::ST_IDLE;
      phase   <= ccenum_pkg::PHASE_IDLE;
      cur_len <= '0;
      idx     <= '0;
    end else begin
      state   <= state_next;
      phase   <= phase_next;
      cur_len <= cur_len_next;
      idx     <= idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    phase_next   = phase;
    cur_len_next = cur_len;
    idx_next     = idx;
    cmd_ready    = 1'b0;
    cand_we      = 1'b0;
    cand_waddr   = '0;
    cand_wdata   = '0;
    cand_raddr   = idx;
    succ_we      = 1'b0;
    succ_re      = 1'b0;
    succ_raddr   = cand_rdata;
    out_push     = 1'b0;
    out_data     = '0;
    unique case (state)
      ccenum_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          unique case (cmd.kind)
            ccenum_pkg::MODE_SUCC_WR: begin
              succ_we = 1'b1;
            end
            ccenum_pkg::MODE_PREFIX_WR: begin
              cand_we    = cmd.slot_in_range;
              cand_waddr = cmd.slot[PW-1:0];
              cand_wdata = cmd.value;
            end
            ccenum_pkg::MODE_START: begin
              if (cfg.prefix_length > cfg.maximum_length ||
                  cfg.maximum_length > LW'(ccenum_pkg::MAX_LEN)) begin
                phase_next   = ccenum_pkg::PHASE_DONE;
                cur_len_next = '0;
              end else begin
                phase_next   = ccenum_pkg::PHASE_WALK;
                cur_len_next = cfg.prefix_length;
              end
            end
            ccenum_pkg::MODE_NEXT: begin
              idx_next   = '0;
              state_next = ccenum_pkg::ST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      ccenum_pkg::ST_EMIT: begin
        if (!out_full) begin
          out_push = 1'b1;
          if (phase != ccenum_pkg::PHASE_WALK) begin
            out_data.exhausted = 1'b1;
            state_next         = ccenum_pkg::ST_IDLE;
          end else if (cur_len == '0) begin
            out_data.last_byte = 1'b1;
            state_next         = ccenum_pkg::ST_ADVANCE;
          end else begin
            out_data.symbol_out       = cand_rdata;
            out_data.position         = idx;
            out_data.candidate_length = cur_len;
            out_data.last_byte        = (LW'(idx) + 1'b1) == cur_len;
            if (out_data.last_byte) begin
              state_next = ccenum_pkg::ST_ADVANCE;
            end else begin
              idx_next = idx + 1'b1;
            end
          end
        end
      end
      ccenum_pkg::ST_ADVANCE: begin
        if (cur_len < limit) begin
          cand_we      = 1'b1;
          cand_waddr   = cur_len[PW-1:0];
          cand_wdata   = cfg.first_symbol;
          cur_len_next = cur_len + 1'b1;
          state_next   = ccenum_pkg::ST_IDLE;
        end else begin
          state_next = ccenum_pkg::ST_LOOKUP;
        end
      end
      ccenum_pkg::ST_LOOKUP: begin
        if (cur_len > cfg.prefix_length) begin
          cand_raddr = len_dec[PW-1:0];
          succ_re    = 1'b1;
          state_next = ccenum_pkg::ST_CHECK;
        end else begin
          phase_next = ccenum_pkg::PHASE_DONE;
          state_next = ccenum_pkg::ST_IDLE;
        end
      end
      ccenum_pkg::ST_CHECK: begin
        if (succ_next_sym != '0) begin
          cand_we    = 1'b1;
          cand_waddr = len_dec[PW-1:0];
          cand_wdata = succ_next_sym;
          state_next = ccenum_pkg::ST_IDLE;
        end else begin
          cur_len_next = len_dec;
          state_next   = ccenum_pkg::ST_LOOKUP;
        end
      end
      default: begin
        state_next = ccenum_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cand_we) begin
      cand[cand_waddr] <= cand_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (succ_we) begin
      succ_mem[cmd.slot] <= cmd.value;
    end
    if (succ_re) begin
      succ_rdata  <= succ_mem[succ_raddr];
      succ_rvalid <= succ_valid[succ_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ccenum_pkg::NSYM; i++) begin
        succ_valid[i] <= 1'b0;
      end
    end else if (succ_we) begin
      succ_valid[cmd.slot] <= 1'b1;
    end
  end

  assign out_full = ocount == ccenum_pkg::Q_CNT_W'(ccenum_pkg::Q_DEPTH);
  assign empty    = ocount == '0;
  assign out_pop  = pop && !empty;
  assign result   = oq[ord_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      owr_ptr <= '0;
      ord_ptr <= '0;
      ocount  <= '0;
    end else begin
      if (out_push) begin
        owr_ptr <= owr_ptr + 1'b1;
      end
      if (out_pop) begin
        ord_ptr <= ord_ptr + 1'b1;
      end
      ocount <= ocount + ccenum_pkg::Q_CNT_W'(out_push) - ccenum_pkg::Q_CNT_W'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      oq[owr_ptr] <= out_data;
    end
  end

endmodule

/* src/charset_candidate_enumerator.sv */
// Top level of the charset candidate enumerator: configuration registers,
// front and back ends. Depends on ccenum_pkg, ccenum_front, ccenum_back and
// the assertion macros header.
`include "charset_candidate_enumerator_macros.svh"

// The enumerator walks, depth first, every string that begins with a loaded
// prefix and grows it up to maximum_length with symbols of a charset, which
// is held as a successor table (an entry of zero marks the last symbol). Each
// input transaction carries a mode: successor write, prefix byte write, start,
// or next. A next transaction returns the current candidate as one result
// transaction per byte (a single marker with candidate_length zero for the
// empty string, or a single result with exhausted set once the walk is over),
// and then advances the walk. Writes and start are handled in the idle state of
// the back end. A next on a candidate of L bytes streams the bytes (one per
// cycle while the result queue has room), then advances, and every backtracking
// step passes through the lookup and check states, since it reads the successor
// memory and waits for its registered data. The successor table is a 256-entry
// memory whose zero reset comes from per-entry valid bits, so no clearing pass
// is needed after reset. Two-deep queues sit on both sides, so the block keeps
// accepting input while a result waits to be popped.
module charset_candidate_enumerator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  ccenum_pkg::in_item_t                  item,
  output logic                                  empty,
  input  logic                                  pop,
  output ccenum_pkg::result_t                   result,
  input  logic                                  wr_en,
  input  logic [ccenum_pkg::REG_IDX_W-1:0]      wr_index,
  input  logic [ccenum_pkg::CFG_W-1:0]          wr_data
);

  ccenum_pkg::cfg_t cfg;
  logic             cmd_valid;
  logic             cmd_ready;
  ccenum_pkg::cmd_t cmd;

  // Configuration registers. Writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        ccenum_pkg::REG_PREFIX_LEN: begin
          cfg.prefix_length <= wr_data[ccenum_pkg::LEN_W-1:0];
        end
        ccenum_pkg::REG_MAX_LEN: begin
          cfg.maximum_length <= wr_data[ccenum_pkg::LEN_W-1:0];
        end
        ccenum_pkg::REG_FIRST_SYM: begin
          cfg.first_symbol <= wr_data[ccenum_pkg::SYM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The front end decodes input transactions and queues them as commands.
  ccenum_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  // The back end runs the walk and queues the result transactions.
  ccenum_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  // An exhausted result carries nothing else.
  `CCENUM_ASSERT_NOW(a_exhausted_clean, clk, rst, !empty && result.exhausted, result.symbol_out == '0 && result.position == '0 && result.candidate_length == '0 && !result.last_byte, "exhausted result has nonzero fields")

  // A byte of a nonempty candidate lies inside it.
  `CCENUM_ASSERT_NOW(a_position_in_range, clk, rst, !empty && !result.exhausted && result.candidate_length != '0, ccenum_pkg::LEN_W'(result.position) < result.candidate_length, "position beyond candidate length")

  // The last byte of a nonempty candidate is at its final position.
  `CCENUM_ASSERT_NOW(a_last_at_end, clk, rst, !empty && result.last_byte && result.candidate_length != '0, ccenum_pkg::LEN_W'(result.position) + 1'b1 == result.candidate_length, "last byte flagged at wrong position")

  // A waiting result does not vanish unless it is popped.
  `CCENUM_ASSERT_NEXT(a_result_kept, clk, rst, !empty && !pop, !empty, "pending result lost without pop")

endmodule
